@@ rtl/osc_pkg.sv @@
// ----------------------------------------------------------------------------
// osc_pkg
// Shared types and constants of the band-limited oscillator.
// ----------------------------------------------------------------------------
package osc_pkg;

  localparam int WAVE_W  = 2;
  localparam int FREQ_W  = 24;
  localparam int PWQ_W   = 16;
  localparam int SMP_W   = 16;
  localparam int SR_W    = 18;

  localparam logic [SR_W-1:0]  SR_RESET   = 18'd48000;
  localparam logic [PWQ_W-1:0] PW_MIN_Q16 = 16'd3277;
  localparam logic [PWQ_W-1:0] PW_MAX_Q16 = 16'd62259;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                 64'd42, 64'd20, 64'd6};

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DTSET,
    S_DT,
    S_BSEL,
    S_BDIV,
    S_BMUL,
    S_FIN
  } osc_state_t;

endpackage

@@ rtl/osc_if.sv @@
// ----------------------------------------------------------------------------
// osc_if
// Request and sample channels of the oscillator (valid/ready).
// ----------------------------------------------------------------------------
interface osc_req_if import osc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WAVE_W-1:0] wave;
  logic [FREQ_W-1:0] freq;
  logic [PWQ_W-1:0]  pulse_width;

  modport source (output valid, wave, freq, pulse_width, input ready);
  modport sink   (input valid, wave, freq, pulse_width, output ready);
endinterface

interface osc_smp_if import osc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

@@ rtl/osc_div.sv @@
// ----------------------------------------------------------------------------
// osc_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osc_div import osc_pkg::*; #(
  parameter int QW = 24,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem0,
  input  logic [DW-1:0] divisor,
  input  logic [QW-1:0] num_bits,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [QW-1:0] bits_r;
  logic [QW-1:0] q_r;
  logic [DW:0]   rem2;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    rem2    = {rem_r, bits_r[QW-1]};
    ge      = rem2 >= {1'b0, div_r};
    rem_nxt = ge ? DW'(rem2 - {1'b0, div_r}) : DW'(rem2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem0;
      div_r  <= divisor;
      bits_r <= num_bits;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      bits_r <= bits_r << 1;
      q_r    <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> rem0 < divisor)
    else $error("divider started with partial remainder not below divisor");

endmodule

@@ rtl/osc_mul.sv @@
// ----------------------------------------------------------------------------
// osc_mul
// Bit-serial shift-add squarer: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module osc_mul import osc_pkg::*; #(
  parameter int W  = 25,
  parameter int RS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     opnd,
  output logic             done,
  output logic [2*W-RS-1:0] res
);

  localparam int CW = $clog2(W + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [W-1:0]    mc_r;
  logic [2*W-1:0]  prod_r;
  logic [W:0]      sum;

  always_comb begin
    sum = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, mc_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r   <= opnd;
      prod_r <= {{W{1'b0}}, opnd};
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[W-1:1]};
    end
  end

  assign done = done_r;
  assign res  = prod_r[2*W-1:RS];

endmodule

@@ rtl/osc_sine.sv @@
// ----------------------------------------------------------------------------
// osc_sine
// Quarter-wave sine ROM with quadrant mirroring and registered read.
// ----------------------------------------------------------------------------
module osc_sine import osc_pkg::*; #(
  parameter int PB    = 24,
  parameter int DEPTH = 1024
) (
  input  logic                    clk,
  input  logic [PB-1:0]           phase,
  output logic signed [SMP_W-1:0] sine_q
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int SW = PB - 2 + 14;

  typedef logic [14:0] tab_t [0:DEPTH];

  function automatic tab_t build_tab();
    longint unsigned x, x2, t, s, e;
    tab_t tb;
    for (int k = 0; k <= DEPTH; k++) begin
      x  = (HALF_PI_Q30 * longint'(k)) / DEPTH;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
        t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[i];
      end
      s = (x * t) >> 30;
      e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tb[k] = 15'(e);
    end
    return tb;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [1:0]    quad;
  logic [SW-1:0] scaled;
  logic [AW-1:0] idx;
  logic [AW-1:0] addr;
  logic [14:0]   rd_r;
  logic          neg_r;

  always_comb begin
    quad   = phase[PB-1:PB-2];
    scaled = SW'(phase[PB-3:0]) * SW'(DEPTH);
    idx    = AW'(scaled >> (PB - 2));
    addr   = quad[0] ? AW'(DEPTH) - idx : idx;
  end

  always_ff @(posedge clk) begin
    rd_r  <= SINE_TAB[addr];
    neg_r <= quad[1];
  end

  assign sine_q = neg_r ? -$signed({1'b0, rd_r}) : $signed({1'b0, rd_r});

endmodule

@@ rtl/polyblep_oscillator.sv @@
// ----------------------------------------------------------------------------
// polyblep_oscillator
// Band-limited sine/triangle/saw/square oscillator, one sample per request.
// ----------------------------------------------------------------------------
// Usage: each in_req transaction (wave, freq, pulse_width) yields exactly one
// out_smp transaction carrying a saturated Q1.15 sample taken at the current
// phase; the phase then advances by dt = freq / sample_rate (max one half).
// cfg_we/cfg_wdata write sample_rate and clear the phase; write only while
// the block is idle.
// Flow: the increment comes from a bit-serial divider that holds the core
// until its quotient is done. Sine and triangle then go to the finish step
// (the divide is skipped when the rate is zero or freq reaches the rate).
// Saw and square add a select step per edge, and per band-limit correction
// that falls near an edge a serial divide and a serial square, so a square
// near both edges runs both; an idle step follows before the next request.
// One request is in work at a time; in_req.ready is high while idle. The
// sample register frees the core, so the next request is accepted while a
// sample still waits; a stalled receiver blocks only the following result.
// Reset: sample_rate returns to 48000, phase to zero, no sample pending.
// ----------------------------------------------------------------------------
module polyblep_oscillator import osc_pkg::*; #(
  parameter int PHASE_BITS       = 24,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [SR_W-1:0] cfg_wdata,
  osc_req_if.sink         in_req,
  osc_smp_if.source       out_smp
);

  localparam int PB = PHASE_BITS;
  localparam int DW = ((PB > SR_W) ? PB : SR_W) + 1;
  localparam int MW = PB + 1;
  localparam int RW = PB + 2;
  localparam int AW = PB + 3;
  localparam logic [PB:0]   ONE  = (PB + 1)'(1) << PB;
  localparam logic [PB-1:0] HALF = PB'(1) << (PB - 1);

  osc_state_t state_r, state_nxt;

  logic [SR_W-1:0]   sr_r;
  logic [PB-1:0]     phase_r;
  logic [PB-1:0]     dt_r;
  wave_t             wave_r;
  logic [FREQ_W-1:0] freq_r;
  logic [PWQ_W-1:0]  pwq_r;
  logic signed [AW-1:0] acc_r;
  logic              slot_r;
  logic              neg_r;
  logic              out_valid_r;
  logic signed [SMP_W-1:0] sample_r;

  // control
  logic in_ready, accept, dt_special, dt_ovf, div_start, mul_start;
  logic dispatch, fin_load, lo_hit, hi_hit, last_slot;
  logic [PB-1:0] dt_special_val, dt_div_val;

  // datapath
  logic [PWQ_W-1:0] pwc;
  logic [PB-1:0]    pw, t_sel;
  logic [PB:0]      one_minus_t;
  logic [DW-1:0]    div_rem0, div_dvs;
  logic [PB-1:0]    div_bits, div_q;
  logic             div_done, mul_done;
  logic [MW-1:0]    mul_opnd;
  logic [RW-1:0]    mul_res;
  logic signed [AW-1:0] p_s, one_s, acc_init, xr, r_full, blep_term;
  logic signed [SMP_W-1:0] r_sat, sine_q;

  osc_div #(.QW(PB), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem0     (div_rem0),
    .divisor  (div_dvs),
    .num_bits (div_bits),
    .done     (div_done),
    .quot     (div_q)
  );

  osc_mul #(.W(MW), .RS(PB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .opnd  (mul_opnd),
    .done  (mul_done),
    .res   (mul_res)
  );

  osc_sine #(.PB(PB), .DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .clk    (clk),
    .phase  (phase_r),
    .sine_q (sine_q)
  );

  // datapath combinational
  always_comb begin
    if (pwq_r < PW_MIN_Q16) begin
      pwc = PW_MIN_Q16;
    end else if (pwq_r > PW_MAX_Q16) begin
      pwc = PW_MAX_Q16;
    end else begin
      pwc = pwq_r;
    end
    pw          = PB'(pwc) << (PB - 16);
    t_sel       = slot_r ? phase_r - pw : phase_r;
    one_minus_t = ONE - {1'b0, t_sel};
    lo_hit      = t_sel < dt_r;
    hi_hit      = {1'b0, t_sel} > (ONE - {1'b0, dt_r});

    dt_ovf         = {2'b00, freq_r[FREQ_W-1:8]} >= sr_r;
    dt_special     = (sr_r == '0) || dt_ovf;
    dt_special_val = ((sr_r == '0) && (freq_r == '0)) ? '0 : HALF;
    dt_div_val     = (div_q > HALF) ? HALF : div_q;

    if (state_r == S_DTSET) begin
      div_rem0 = DW'(freq_r[FREQ_W-1:8]);
      div_dvs  = DW'(sr_r);
      div_bits = PB'(freq_r[7:0]) << (PB - 8);
    end else begin
      div_rem0 = lo_hit ? DW'(t_sel) : DW'(one_minus_t);
      div_dvs  = DW'(dt_r);
      div_bits = '0;
    end
    mul_opnd = ONE - {1'b0, div_q};

    p_s   = $signed(AW'(phase_r));
    one_s = $signed(AW'(ONE));
    unique case (wave_r)
      WAVE_TRI:    acc_init = (phase_r < HALF) ? (p_s <<< 2) - one_s
                                               : (one_s <<< 1) + one_s - (p_s <<< 2);
      WAVE_SAW:    acc_init = (p_s <<< 1) - one_s;
      WAVE_SQUARE: acc_init = (phase_r < pw) ? one_s : -one_s;
      default:     acc_init = '0;
    endcase
    blep_term = $signed(AW'(mul_res));

    xr     = acc_r + $signed(AW'(1) << (PB - 16));
    r_full = xr >>> (PB - 15);
    if (r_full > $signed(AW'(32767))) begin
      r_sat = 16'sd32767;
    end else if (r_full < -$signed(AW'(32768))) begin
      r_sat = -16'sd32768;
    end else begin
      r_sat = SMP_W'(r_full);
    end
    last_slot = (wave_r != WAVE_SQUARE) || slot_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_req.valid) state_nxt = S_DTSET;
      S_DTSET: begin
        if (!dt_special) begin
          state_nxt = S_DT;
        end else if (wave_r == WAVE_SINE || wave_r == WAVE_TRI) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_BSEL;
        end
      end
      S_DT: begin
        if (div_done) begin
          if (wave_r == WAVE_SINE || wave_r == WAVE_TRI) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_BSEL;
          end
        end
      end
      S_BSEL: begin
        if (lo_hit || hi_hit) begin
          state_nxt = S_BDIV;
        end else if (last_slot) begin
          state_nxt = S_FIN;
        end
      end
      S_BDIV:  if (div_done) state_nxt = S_BMUL;
      S_BMUL: begin
        if (mul_done) begin
          state_nxt = last_slot ? S_FIN : S_BSEL;
        end
      end
      S_FIN:   if (!out_valid_r || out_smp.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    accept    = in_ready && in_req.valid;
    div_start = ((state_r == S_DTSET) && !dt_special) ||
                ((state_r == S_BSEL) && (lo_hit || hi_hit));
    mul_start = (state_r == S_BDIV) && div_done;
    dispatch  = ((state_r == S_DTSET) && dt_special) ||
                ((state_r == S_DT) && div_done);
    fin_load  = (state_r == S_FIN) && (!out_valid_r || out_smp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sr_r        <= SR_RESET;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      slot_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        sr_r    <= cfg_wdata;
        phase_r <= '0;
      end else if (fin_load) begin
        phase_r <= phase_r + dt_r;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_smp.ready) begin
        out_valid_r <= 1'b0;
      end
      if (dispatch) begin
        slot_r <= 1'b0;
      end else if ((state_r == S_BSEL && !(lo_hit || hi_hit) && !last_slot) ||
                   (state_r == S_BMUL && mul_done && !last_slot)) begin
        slot_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wave_r <= wave_t'(in_req.wave);
      freq_r <= in_req.freq;
      pwq_r  <= in_req.pulse_width;
    end
    if (state_r == S_DTSET && dt_special) begin
      dt_r <= dt_special_val;
    end else if (state_r == S_DT && div_done) begin
      dt_r <= dt_div_val;
    end
    if (dispatch) begin
      acc_r <= acc_init;
    end else if (state_r == S_BMUL && mul_done) begin
      acc_r <= neg_r ? acc_r - blep_term : acc_r + blep_term;
    end
    // saw subtracts its edge term, square subtracts the falling-edge term
    if (div_start && state_r == S_BSEL) begin
      neg_r <= lo_hit ^ ((wave_r == WAVE_SAW) || slot_r);
    end
    if (fin_load) begin
      sample_r <= (wave_r == WAVE_SINE) ? sine_q : r_sat;
    end
  end

  assign in_req.ready   = in_ready;
  assign out_smp.valid  = out_valid_r;
  assign out_smp.sample = sample_r;

  a_dt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSEL || state_r == S_FIN) |-> dt_r <= HALF)
    else $error("phase increment above one half");
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!fin_load && !cfg_we) |=> phase_r == $past(phase_r))
    else $error("phase moved without a sample or a rate write");
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("sample presented outside finish step");
  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    (div_start && mul_start) |-> 1'b0)
    else $error("divider and squarer started together");

endmodule

@@ verif/tb_polyblep_oscillator.sv @@
// ----------------------------------------------------------------------------
// tb_polyblep_oscillator
// Self-checking bench for the band-limited oscillator: drives sample
// requests under several sample rates and idling mixes, predicts every
// sample with an in-bench fixed-point model and compares each output
// transaction in order.
// ----------------------------------------------------------------------------
module tb_polyblep_oscillator;
  import osc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = 24;
  localparam int TAB_DEPTH = 1024;
  localparam longint ONE = 64'sd1 << PB;
  localparam longint HALF = ONE >>> 1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SR_W-1:0] cfg_wdata;

  osc_req_if req_if ();
  osc_smp_if smp_if ();

  polyblep_oscillator #(.PHASE_BITS(PB), .SINE_TABLE_DEPTH(TAB_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_if.sink),
    .out_smp  (smp_if.source)
  );

  // predictor state
  longint unsigned  sine_lut [TAB_DEPTH+1];
  logic [SR_W-1:0]  osc_rate;
  longint unsigned  osc_phase;
  logic signed [SMP_W-1:0] sample_q[$];

  int mismatches;
  int sender_idle_pct;
  int stall_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic void build_sine_lut();
    longint unsigned x, x2, t, s, e;
    for (int k = 0; k <= TAB_DEPTH; k++) begin
      x = (HALF_PI_Q30 * longint'(k)) / TAB_DEPTH;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (int i = 0; i < 6; i++) t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[i];
      s = (x * t) >> 30;
      e = (s * 32767 + (64'd1 << 29)) >> 30;
      if (e > 32767) e = 32767;
      sine_lut[k] = e;
    end
  endfunction

  function automatic longint edge_blep(longint t, longint dt);
    longint u;
    longint unsigned d;
    if (t < dt) begin
      u = longint'((longint'(t) <<< PB) / dt);
      d = ONE - u;
      return -longint'((d * d) >> PB);
    end
    if (t > ONE - dt) begin
      u = longint'(((ONE - t) <<< PB) / dt);
      d = ONE - u;
      return longint'((d * d) >> PB);
    end
    return 0;
  endfunction

  function automatic logic signed [SMP_W-1:0] predict_sample(
      wave_t wave, logic [FREQ_W-1:0] freq, logic [PWQ_W-1:0] pwq_in);
    longint p, dt, x, r, pw, t2;
    longint unsigned q, idx, quad;
    logic [PWQ_W-1:0] pwq;
    p = longint'(osc_phase);
    if (osc_rate == 0) begin
      dt = (freq != 0) ? HALF : 0;
    end else begin
      q = (longint'(freq) << PB) / (longint'(osc_rate) * 256);
      dt = (q > HALF) ? HALF : longint'(q);
    end
    case (wave)
      WAVE_SINE: begin
        quad = (osc_phase >> (PB - 2)) & 3;
        idx = ((osc_phase & ((64'd1 << (PB - 2)) - 1)) * TAB_DEPTH) >> (PB - 2);
        if (quad[0]) idx = TAB_DEPTH - idx;
        r = quad[1] ? -longint'(sine_lut[idx]) : longint'(sine_lut[idx]);
      end
      default: begin
        if (wave == WAVE_TRI) begin
          x = (p < HALF) ? 4 * p - ONE : 3 * ONE - 4 * p;
        end else if (wave == WAVE_SAW) begin
          x = 2 * p - ONE - edge_blep(p, dt);
        end else begin
          pwq = pwq_in;
          if (pwq < PW_MIN_Q16) pwq = PW_MIN_Q16;
          if (pwq > PW_MAX_Q16) pwq = PW_MAX_Q16;
          pw = longint'(pwq) <<< (PB - 16);
          x = (p < pw) ? ONE : -ONE;
          x += edge_blep(p, dt);
          t2 = p - pw + ONE;
          if (t2 >= ONE) t2 -= ONE;
          x -= edge_blep(t2, dt);
        end
        r = (x + (64'sd1 <<< (PB - 16))) >>> (PB - 15);
      end
    endcase
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    osc_phase = (osc_phase + longint'(dt)) & ((64'd1 << PB) - 1);
    return r[SMP_W-1:0];
  endfunction

  // sample checker
  always @(posedge clk) begin
    if (rst_n && smp_if.valid && smp_if.ready) begin
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", smp_if.sample);
      end else begin
        if (smp_if.sample !== sample_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %0d, got %0d", sample_q[0], smp_if.sample);
        end
        void'(sample_q.pop_front());
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    smp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        smp_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        smp_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_req(wave_t wave, logic [FREQ_W-1:0] freq, logic [PWQ_W-1:0] pw);
    if ($urandom_range(99) < sender_idle_pct) repeat ($urandom_range(1, 4)) @(negedge clk);
    req_if.valid = 1'b1;
    req_if.wave = wave;
    req_if.freq = freq;
    req_if.pulse_width = pw;
    do @(posedge clk); while (!req_if.ready);
    sample_q.push_back(predict_sample(wave, freq, pw));
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_rate(logic [SR_W-1:0] rate);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = rate;
    @(negedge clk);
    cfg_we = 1'b0;
    osc_rate = rate;
    osc_phase = 0;
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(9))
      0: return FREQ_W'($urandom);
      1: return $urandom_range(0, 3) == 0 ? 24'd0 : 24'hFFFFFF;
      default: return FREQ_W'($urandom_range(20, 20000) * 256 + $urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PWQ_W-1:0] rand_pw();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return PWQ_W'($urandom_range(3270, 3285));
      3: return PWQ_W'($urandom_range(62250, 62265));
      default: return PWQ_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_req(WAVE_SINE, 24'd0, 16'd0);
    send_req(WAVE_SINE, 24'hFFFFFF, 16'hFFFF);
    send_req(WAVE_TRI, 24'hFFFFFF, 16'd0);
    send_req(WAVE_TRI, FREQ_W'(440 * 256), 16'h8000);
    send_req(WAVE_SAW, 24'hFFFFFF, 16'h8000);
    send_req(WAVE_SAW, FREQ_W'(1000 * 256), 16'd0);
    send_req(WAVE_SQUARE, FREQ_W'(1000 * 256), 16'd0);
    send_req(WAVE_SQUARE, FREQ_W'(1000 * 256), 16'hFFFF);
    send_req(WAVE_SQUARE, FREQ_W'(5000 * 256), PW_MIN_Q16);
    send_req(WAVE_SQUARE, FREQ_W'(5000 * 256), PW_MAX_Q16);
    send_req(WAVE_SQUARE, 24'hFFFFFF, 16'h8000);
    send_req(WAVE_SAW, 24'd1, 16'h5555);
  endtask

  // zero rate gives dt of one half: phase toggles 0 / half, hitting the triangle peak
  task automatic test_rate_extremes();
    write_rate(18'd0);
    repeat (2) send_req(WAVE_TRI, 24'd1, 16'd0);
    send_req(WAVE_SAW, 24'd0, 16'd0);
    send_req(WAVE_SQUARE, 24'd7, 16'hAAAA);
    send_req(WAVE_SINE, 24'd3, 16'd0);
    write_rate(18'd1);
    send_req(WAVE_SAW, 24'd200, 16'd0);
    send_req(WAVE_SINE, 24'd300, 16'd0);
    write_rate(18'h3FFFF);
    send_req(WAVE_SQUARE, 24'hFFFFFF, 16'h1234);
    send_req(WAVE_TRI, 24'hFFFFFF, 16'hFFFF);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_req(wave_t'($urandom_range(3)), rand_freq(), rand_pw());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    test_random(12);
    drain();
    test_random(10);
  endtask

  initial begin
    mismatches = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.wave = '0;
    req_if.freq = '0;
    req_if.pulse_width = '0;
    build_sine_lut();
    osc_rate = SR_RESET;
    osc_phase = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_rate_extremes();

    write_rate(18'd48000);
    sender_idle_pct = 0;  stall_pct = 0;  test_random(340);
    write_rate(18'd8000);
    sender_idle_pct = 61; stall_pct = 0;  test_random(330);
    write_rate(18'd192000);
    sender_idle_pct = 0;  stall_pct = 61; test_random(330);
    write_rate(18'd44100);
    sender_idle_pct = 34; stall_pct = 34; test_random(330);
    test_backpressure();

    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/osc_pkg.sv
rtl/osc_if.sv
rtl/osc_div.sv
rtl/osc_mul.sv
rtl/osc_sine.sv
rtl/polyblep_oscillator.sv
verif/tb_polyblep_oscillator.sv
